/* rtl/core/first_fit_block_allocator_core_defines.svh */
// Assertion helpers for the allocator core.
// Both expect clk_i and rst_ni in the scope of use.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// cond must hold at every clock edge outside reset
`define FFBA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/ffba_pkg.sv */
`timescale 1ns / 1ps
package ffba_pkg;

  // fixed field widths
  localparam int unsigned REQ_W        = 21;
  localparam int unsigned REL_ADDR_W   = 20;
  localparam int unsigned OUT_ADDR_W   = 20;
  localparam int unsigned ARENA_W      = 21;
  localparam int unsigned IN_TDATA_W   = 48;
  localparam int unsigned OUT_TDATA_W  = 24;
  // rounded request plus header
  localparam int unsigned TOT_W        = REQ_W + 2;

  localparam int unsigned HDR_BYTES    = 25;
  localparam int unsigned ALIGN_BYTES  = 16;
  localparam int unsigned MIN_BYTES    = 64;

  localparam logic [ARENA_W-1:0] ARENA_RESET = 21'h10_0000;

  localparam int unsigned DEF_MAX_BLOCKS      = 64;
  localparam int unsigned DEF_ARENA_ADDR_BITS = 20;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_NO_FIT  = 2'd2,
    STAT_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_PREP_A,
    ST_PREP_B,
    ST_PREP_C,
    ST_PREP_F,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SPLIT_CHK,
    ST_SH_RD,
    ST_SH_WR,
    ST_REM_ST,
    ST_REM_SZ,
    ST_GRANT,
    ST_MERGE_P,
    ST_FREE_NXT,
    ST_NXT_CHK,
    ST_RM_RD,
    ST_RM_WR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic we;
    logic re;
  } mem_req_t;

  typedef struct packed {
    logic ge;   // a >= b on a subtract
    logic eq;   // a == b on a subtract
  } alu_flags_t;

endpackage

/* rtl/core/first_fit_block_allocator_core.sv */
`timescale 1ns / 1ps
// Channel    Dir  Handshake                      Payload (lowest bit up)
// s_axis     in   s_axis_tvalid_i/s_axis_tready_o tuser: command; tdata: request_size,
//                                                 release_address
// m_axis     out  m_axis_tvalid_o/m_axis_tready_i tuser: status; tdata: granted_address
// cfg        in   cfg_valid_i/cfg_ready_o         cfg_data_i: arena_bytes
//
// The core takes one item at a time. The block table sits in a single-port memory
// with registered read, so the scan reads and then checks each entry visited; each
// entry shifted on a split or removed on a merge takes a read and a write. An
// allocate rounds and sizes the request, scans, and on a split shifts the later
// entries up and writes the remainder before the grant; a free checks the address,
// scans, then merges with a free neighbour and removes the absorbed entry; a scan
// miss visits every block. Reset and each arena write load the table as one free
// block, with s_axis not ready meanwhile. A result waiting on m_axis lets the next
// item in; that item's result is held until the output register empties.
module first_fit_block_allocator_core #(
  parameter int unsigned MAX_BLOCKS      = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned ARENA_ADDR_BITS = ffba_pkg::DEF_ARENA_ADDR_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request items
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [ffba_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,  // request_size, release_address
  input  logic [0:0]                         s_axis_tuser_i,  // command
  // result items
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [ffba_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,  // granted_address
  output logic [1:0]                         m_axis_tuser_o,  // status
  // arena size register
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ffba_pkg::ARENA_W-1:0]       cfg_data_i
);
  import ffba_pkg::*;

  localparam int unsigned IDX_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned START_W = ARENA_ADDR_BITS;
  localparam int unsigned SIZE_W  = ARENA_ADDR_BITS + 1;
  localparam int unsigned ENT_W   = START_W + SIZE_W + 1;
  localparam int unsigned ALU_W   = (SIZE_W > TOT_W) ? SIZE_W : TOT_W;
  localparam int unsigned LIM_W   = (SIZE_W > ARENA_W) ? SIZE_W : ARENA_W;

  logic [ARENA_W-1:0]    arena_q;
  logic [LIM_W-1:0]      arena_ext;
  logic [LIM_W-1:0]      lim_top;
  logic [LIM_W-1:0]      lim_min;
  logic [LIM_W-1:0]      limit;
  logic                  cfg_we;

  mem_req_t              mem_req;
  logic [IDX_W-1:0]      raddr, waddr;
  logic [ENT_W-1:0]      wdata, rdata;
  logic [ALU_W-1:0]      alu_a, alu_b, alu_res;
  alu_op_e               alu_op;
  alu_flags_t            alu_flags;
  status_e               out_status;
  logic [OUT_ADDR_W-1:0] out_addr;

  // register is always writable; writes must come only while idle, unchecked by the block
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q <= ARENA_RESET;
    end else if (cfg_we) begin
      arena_q <= cfg_data_i;
    end
  end

  // clamp the arena to [minimum block, 2^ARENA_ADDR_BITS]
  assign arena_ext = LIM_W'(arena_q);
  assign lim_top   = LIM_W'(1) << ARENA_ADDR_BITS;
  assign lim_min   = LIM_W'(MIN_BYTES);
  assign limit     = (arena_ext < lim_min) ? lim_min :
                     (arena_ext > lim_top) ? lim_top : arena_ext;

  ffba_ctrl #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .ARENA_ADDR_BITS (ARENA_ADDR_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .reload_i     (cfg_we),
    .limit_i      (limit[SIZE_W-1:0]),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_cmd_i     (cmd_e'(s_axis_tuser_i[0])),
    .in_req_i     (s_axis_tdata_i[REQ_W-1:0]),
    .in_addr_i    (s_axis_tdata_i[REQ_W +: REL_ADDR_W]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (out_status),
    .out_addr_o   (out_addr),
    .mem_o        (mem_req),
    .raddr_o      (raddr),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .rdata_i      (rdata),
    .alu_a_o      (alu_a),
    .alu_b_o      (alu_b),
    .alu_op_o     (alu_op),
    .alu_res_i    (alu_res),
    .alu_flags_i  (alu_flags)
  );

  // one adder serves sizing, fit and address compares, split, merge and grant arithmetic
  ffba_alu #(
    .W (ALU_W)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .op_i    (alu_op),
    .res_o   (alu_res),
    .flags_o (alu_flags)
  );

  ffba_table #(
    .MAX_BLOCKS      (MAX_BLOCKS),
    .ARENA_ADDR_BITS (ARENA_ADDR_BITS)
  ) u_table (
    .clk_i   (clk_i),
    .mem_i   (mem_req),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign m_axis_tuser_o = out_status;
  assign m_axis_tdata_o = {{(OUT_TDATA_W - OUT_ADDR_W){1'b0}}, out_addr};

endmodule

/* rtl/core/ffba_alu.sv */
`timescale 1ns / 1ps
module ffba_alu #(
  parameter int unsigned W = 23
) (
  input  logic [W-1:0]          a_i,
  input  logic [W-1:0]          b_i,
  input  ffba_pkg::alu_op_e     op_i,
  output logic [W-1:0]          res_o,
  output ffba_pkg::alu_flags_t  flags_o
);
  import ffba_pkg::*;

  logic         sub;
  logic [W-1:0] b_eff;
  logic [W:0]   sum;

  // single adder, subtract by inverted operand and carry in
  assign sub   = (op_i == ALU_SUB);
  assign b_eff = sub ? ~b_i : b_i;
  assign sum   = {1'b0, a_i} + {1'b0, b_eff} + {{W{1'b0}}, sub};

  assign res_o      = sum[W-1:0];
  assign flags_o.ge = sum[W];
  assign flags_o.eq = (sum[W-1:0] == '0);

endmodule

/* rtl/core/ffba_table.sv */
`timescale 1ns / 1ps
module ffba_table #(
  parameter int unsigned MAX_BLOCKS      = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned ARENA_ADDR_BITS = ffba_pkg::DEF_ARENA_ADDR_BITS,
  localparam int unsigned IDX_W          = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int unsigned ENT_W          = 2 * ARENA_ADDR_BITS + 2
) (
  input  logic                clk_i,
  input  ffba_pkg::mem_req_t  mem_i,
  input  logic [IDX_W-1:0]    waddr_i,
  input  logic [ENT_W-1:0]    wdata_i,
  input  logic [IDX_W-1:0]    raddr_i,
  output logic [ENT_W-1:0]    rdata_o
);
  import ffba_pkg::*;

  // entry: {start, size, free}
  logic [ENT_W-1:0] mem_q [MAX_BLOCKS];
  logic [ENT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (mem_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ffba_ctrl.sv */
`timescale 1ns / 1ps
`include "first_fit_block_allocator_core_defines.svh"
module ffba_ctrl #(
  parameter int unsigned MAX_BLOCKS      = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned ARENA_ADDR_BITS = ffba_pkg::DEF_ARENA_ADDR_BITS,
  localparam int unsigned IDX_W          = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int unsigned CNT_W          = $clog2(MAX_BLOCKS + 1),
  localparam int unsigned START_W        = ARENA_ADDR_BITS,
  localparam int unsigned SIZE_W         = ARENA_ADDR_BITS + 1,
  localparam int unsigned ENT_W          = START_W + SIZE_W + 1,
  localparam int unsigned ALU_W          = (SIZE_W > ffba_pkg::TOT_W) ? SIZE_W
                                                                      : ffba_pkg::TOT_W
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                reload_i,
  input  logic [SIZE_W-1:0]                   limit_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  ffba_pkg::cmd_e                      in_cmd_i,
  input  logic [ffba_pkg::REQ_W-1:0]          in_req_i,
  input  logic [ffba_pkg::REL_ADDR_W-1:0]     in_addr_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output ffba_pkg::status_e                   out_status_o,
  output logic [ffba_pkg::OUT_ADDR_W-1:0]     out_addr_o,
  output ffba_pkg::mem_req_t                  mem_o,
  output logic [IDX_W-1:0]                    raddr_o,
  output logic [IDX_W-1:0]                    waddr_o,
  output logic [ENT_W-1:0]                    wdata_o,
  input  logic [ENT_W-1:0]                    rdata_i,
  output logic [ALU_W-1:0]                    alu_a_o,
  output logic [ALU_W-1:0]                    alu_b_o,
  output ffba_pkg::alu_op_e                   alu_op_o,
  input  logic [ALU_W-1:0]                    alu_res_i,
  input  ffba_pkg::alu_flags_t                alu_flags_i
);
  import ffba_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic [CNT_W-1:0]        k_q, k_d;
  logic                    prev_ok_q, prev_ok_d;
  logic                    out_valid_q, out_valid_d;

  cmd_e                    cmd_q, cmd_d;
  logic [ALU_W-1:0]        key_q, key_d;     // release address, then address less header
  logic [ALU_W-1:0]        tot_q, tot_d;
  logic [ALU_W-1:0]        totp_q, totp_d;   // total plus minimum block
  logic [ENT_W-1:0]        cur_q, cur_d;
  logic [ENT_W-1:0]        prev_q, prev_d;
  logic                    split_q, split_d;
  logic [START_W-1:0]      rem_start_q, rem_start_d;
  status_e                 res_status_q, res_status_d;
  logic [OUT_ADDR_W-1:0]   res_addr_q, res_addr_d;
  status_e                 out_status_q, out_status_d;
  logic [OUT_ADDR_W-1:0]   out_addr_q, out_addr_d;

  logic                    accept;
  logic                    out_load;
  logic [CNT_W-1:0]        idx_p1;
  logic [CNT_W-1:0]        k_p1;
  logic [CNT_W-1:0]        k_m1;
  logic                    scan_more;
  logic                    next_exists;
  logic                    shift_more;
  logic                    rm_more;
  logic                    scan_hit;
  logic                    split_ok;
  logic                    merge_prev;
  logic                    req_zero;
  logic                    addr_zero;

  logic [START_W-1:0]      rd_start, cur_start, prev_start;
  logic [SIZE_W-1:0]       rd_size, cur_size, prev_size;
  logic                    rd_free, prev_free;

  assign rd_start   = rdata_i[ENT_W-1 -: START_W];
  assign rd_size    = rdata_i[SIZE_W:1];
  assign rd_free    = rdata_i[0];
  assign cur_start  = cur_q[ENT_W-1 -: START_W];
  assign cur_size   = cur_q[SIZE_W:1];
  assign prev_start = prev_q[ENT_W-1 -: START_W];
  assign prev_size  = prev_q[SIZE_W:1];
  assign prev_free  = prev_q[0];

  assign in_ready_o = (state_q == ST_IDLE) && !reload_i;
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign idx_p1      = idx_q + CNT_ONE;
  assign k_p1        = k_q + CNT_ONE;
  assign k_m1        = k_q - CNT_ONE;
  assign scan_more   = (idx_q < cnt_q);
  assign next_exists = (idx_p1 < cnt_q);
  assign shift_more  = (k_q > idx_p1);
  assign rm_more     = (k_p1 < cnt_q);

  assign scan_hit   = (cmd_q == CMD_ALLOC) ? (rd_free && alu_flags_i.ge) : alu_flags_i.eq;
  assign split_ok   = alu_flags_i.ge && (cnt_q < CNT_MAX);
  assign merge_prev = prev_ok_q && prev_free;
  assign req_zero   = (in_req_i == '0);
  assign addr_zero  = (in_addr_i == '0);

  function automatic logic [IDX_W-1:0] k_idx_m1(logic [CNT_W-1:0] i);
    logic [CNT_W-1:0] m;
    m = i - CNT_ONE;
    return m[IDX_W-1:0];
  endfunction

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT:      state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd_i == CMD_ALLOC) begin
            state_d = req_zero ? ST_DONE : ST_PREP_A;
          end else begin
            state_d = addr_zero ? ST_DONE : ST_PREP_F;
          end
        end
      end
      ST_PREP_A:    state_d = ST_PREP_B;
      ST_PREP_B:    state_d = ST_PREP_C;
      ST_PREP_C:    state_d = ST_SCAN_RD;
      ST_PREP_F:    state_d = alu_flags_i.ge ? ST_SCAN_RD : ST_DONE;
      ST_SCAN_RD:   state_d = scan_more ? ST_SCAN_CHK : ST_DONE;
      ST_SCAN_CHK: begin
        if (!scan_hit) begin
          state_d = ST_SCAN_RD;
        end else if (cmd_q == CMD_ALLOC) begin
          state_d = ST_SPLIT_CHK;
        end else begin
          state_d = merge_prev ? ST_MERGE_P : ST_FREE_NXT;
        end
      end
      ST_SPLIT_CHK: state_d = split_ok ? ST_SH_RD : ST_GRANT;
      ST_SH_RD:     state_d = shift_more ? ST_SH_WR : ST_REM_ST;
      ST_SH_WR:     state_d = ST_SH_RD;
      ST_REM_ST:    state_d = ST_REM_SZ;
      ST_REM_SZ:    state_d = ST_GRANT;
      ST_GRANT:     state_d = ST_DONE;
      ST_MERGE_P:   state_d = ST_RM_RD;
      ST_FREE_NXT:  state_d = next_exists ? ST_NXT_CHK : ST_DONE;
      ST_NXT_CHK:   state_d = rd_free ? ST_RM_RD : ST_DONE;
      ST_RM_RD:     state_d = rm_more ? ST_RM_WR : ST_DONE;
      ST_RM_WR:     state_d = ST_RM_RD;
      ST_DONE:      state_d = out_load ? ST_IDLE : ST_DONE;
      default:      state_d = ST_INIT;
    endcase
    if (reload_i) begin
      state_d = ST_INIT;
    end
  end

  // table and shared unit controls
  always_comb begin
    mem_o    = '0;
    raddr_o  = '0;
    waddr_o  = '0;
    wdata_o  = '0;
    alu_a_o  = '0;
    alu_b_o  = '0;
    alu_op_o = ALU_ADD;
    unique case (state_q)
      ST_INIT: begin
        mem_o.we = 1'b1;
        wdata_o  = {{START_W{1'b0}}, limit_i, 1'b1};
      end
      ST_PREP_A: begin
        // request sits in tot_q here
        alu_a_o = tot_q;
        alu_b_o = ALU_W'(ALIGN_BYTES - 1);
      end
      ST_PREP_B: begin
        alu_a_o = tot_q;
        alu_b_o = ALU_W'(HDR_BYTES);
      end
      ST_PREP_C: begin
        alu_a_o = tot_q;
        alu_b_o = ALU_W'(MIN_BYTES);
      end
      ST_PREP_F: begin
        alu_a_o  = key_q;
        alu_b_o  = ALU_W'(HDR_BYTES);
        alu_op_o = ALU_SUB;
      end
      ST_SCAN_RD: begin
        mem_o.re = scan_more;
        raddr_o  = idx_q[IDX_W-1:0];
      end
      ST_SCAN_CHK: begin
        alu_op_o = ALU_SUB;
        if (cmd_q == CMD_ALLOC) begin
          alu_a_o = ALU_W'(rd_size);
          alu_b_o = tot_q;
        end else begin
          alu_a_o = ALU_W'(rd_start);
          alu_b_o = key_q;
        end
      end
      ST_SPLIT_CHK: begin
        alu_a_o  = ALU_W'(cur_size);
        alu_b_o  = totp_q;
        alu_op_o = ALU_SUB;
      end
      ST_SH_RD: begin
        mem_o.re = shift_more;
        raddr_o  = k_m1[IDX_W-1:0];
      end
      ST_SH_WR: begin
        mem_o.we = 1'b1;
        waddr_o  = k_q[IDX_W-1:0];
        wdata_o  = rdata_i;
      end
      ST_REM_ST: begin
        alu_a_o = ALU_W'(cur_start);
        alu_b_o = tot_q;
      end
      ST_REM_SZ: begin
        alu_a_o  = ALU_W'(cur_size);
        alu_b_o  = tot_q;
        alu_op_o = ALU_SUB;
        mem_o.we = 1'b1;
        waddr_o  = idx_p1[IDX_W-1:0];
        wdata_o  = {rem_start_q, alu_res_i[SIZE_W-1:0], 1'b1};
      end
      ST_GRANT: begin
        alu_a_o  = ALU_W'(cur_start);
        alu_b_o  = ALU_W'(HDR_BYTES);
        mem_o.we = 1'b1;
        waddr_o  = idx_q[IDX_W-1:0];
        wdata_o  = {cur_start, (split_q ? tot_q[SIZE_W-1:0] : cur_size), 1'b0};
      end
      ST_MERGE_P: begin
        alu_a_o  = ALU_W'(prev_size);
        alu_b_o  = ALU_W'(cur_size);
        mem_o.we = 1'b1;
        waddr_o  = k_idx_m1(idx_q);
        wdata_o  = {prev_start, alu_res_i[SIZE_W-1:0], 1'b1};
      end
      ST_FREE_NXT: begin
        mem_o.re = next_exists;
        mem_o.we = !next_exists;
        raddr_o  = idx_p1[IDX_W-1:0];
        waddr_o  = idx_q[IDX_W-1:0];
        wdata_o  = {cur_start, cur_size, 1'b1};
      end
      ST_NXT_CHK: begin
        alu_a_o  = ALU_W'(cur_size);
        alu_b_o  = ALU_W'(rd_size);
        mem_o.we = 1'b1;
        waddr_o  = idx_q[IDX_W-1:0];
        wdata_o  = rd_free ? {cur_start, alu_res_i[SIZE_W-1:0], 1'b1}
                           : {cur_start, cur_size, 1'b1};
      end
      ST_RM_RD: begin
        mem_o.re = rm_more;
        raddr_o  = k_p1[IDX_W-1:0];
      end
      ST_RM_WR: begin
        mem_o.we = 1'b1;
        waddr_o  = k_q[IDX_W-1:0];
        wdata_o  = rdata_i;
      end
      ST_IDLE, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    k_d          = k_q;
    prev_ok_d    = prev_ok_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    tot_d        = tot_q;
    totp_d       = totp_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    split_d      = split_q;
    rem_start_d  = rem_start_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;

    case (state_q)
      ST_INIT: cnt_d = CNT_ONE;
      ST_IDLE: begin
        if (accept) begin
          cmd_d        = in_cmd_i;
          tot_d        = ALU_W'(in_req_i);
          key_d        = ALU_W'(in_addr_i);
          idx_d        = '0;
          prev_ok_d    = 1'b0;
          split_d      = 1'b0;
          res_addr_d   = '0;
          res_status_d = STAT_OK;
          if ((in_cmd_i == CMD_ALLOC) ? req_zero : addr_zero) begin
            res_status_d = STAT_IGNORED;
          end
        end
      end
      ST_PREP_A: tot_d  = alu_res_i & ~ALU_W'(ALIGN_BYTES - 1);
      ST_PREP_B: tot_d  = (alu_res_i < ALU_W'(MIN_BYTES)) ? ALU_W'(MIN_BYTES) : alu_res_i;
      ST_PREP_C: totp_d = alu_res_i;
      ST_PREP_F: begin
        key_d = alu_res_i;
        if (!alu_flags_i.ge) begin
          res_status_d = STAT_UNKNOWN;
        end
      end
      ST_SCAN_RD: begin
        if (!scan_more) begin
          res_status_d = (cmd_q == CMD_ALLOC) ? STAT_NO_FIT : STAT_UNKNOWN;
        end
      end
      ST_SCAN_CHK: begin
        if (scan_hit) begin
          cur_d = rdata_i;
        end else begin
          prev_d    = rdata_i;
          prev_ok_d = 1'b1;
          idx_d     = idx_p1;
        end
      end
      ST_SPLIT_CHK: begin
        split_d = split_ok;
        k_d     = cnt_q;
      end
      ST_SH_WR:   k_d         = k_m1;
      ST_REM_ST:  rem_start_d = alu_res_i[START_W-1:0];
      ST_REM_SZ:  cnt_d       = cnt_q + CNT_ONE;
      ST_GRANT:   res_addr_d  = alu_res_i[OUT_ADDR_W-1:0];
      ST_MERGE_P: k_d         = idx_q;
      ST_NXT_CHK: k_d         = idx_p1;
      ST_RM_RD: begin
        if (!rm_more) begin
          cnt_d = cnt_q - CNT_ONE;
        end
      end
      ST_RM_WR:   k_d         = k_p1;
      ST_DONE: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= CNT_ONE;
      idx_q       <= '0;
      k_q         <= '0;
      prev_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      prev_ok_q   <= prev_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    key_q        <= key_d;
    tot_q        <= tot_d;
    totp_q       <= totp_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    split_q      <= split_d;
    rem_start_q  <= rem_start_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_addr_o   = out_addr_q;

  `FFBA_ASSERT_ALWAYS(a_cnt_range, (cnt_q != '0) && (cnt_q <= CNT_MAX), "block count out of range")
  `FFBA_ASSERT_NEXT(a_busy_after_accept, accept, (state_q != ST_IDLE), "ready right after an item")
  `FFBA_ASSERT_ALWAYS(a_port_excl, !(mem_o.we && mem_o.re), "table read and write together")
  `FFBA_ASSERT_ALWAYS(a_scan_bound, (state_q != ST_SCAN_RD) || (idx_q <= cnt_q), "scan index past count")

endmodule

/* sim/tb_first_fit_block_allocator_core.sv */
`timescale 1ns / 1ps
module tb_first_fit_block_allocator_core;
  import ffba_pkg::*;

  localparam int unsigned CLK_PERIOD_NS   = 12;
  localparam int unsigned TABLE_DEPTH     = DEF_MAX_BLOCKS;
  localparam int unsigned ARENA_CEILING   = 1 << DEF_ARENA_ADDR_BITS;
  // drain wait, sized from the table depth with margin
  localparam int unsigned DRAIN_CYCLES    = 4 * TABLE_DEPTH + 16;
  localparam int unsigned WATCHDOG_CYCLES = 3_000_000;
  localparam int unsigned PAD_W           = IN_TDATA_W - REQ_W - REL_ADDR_W;

  typedef struct packed {
    status_e                status;
    logic [OUT_ADDR_W-1:0]  granted;
  } outcome_t;

  typedef struct packed {
    logic [ARENA_W-1:0] start;
    logic [ARENA_W-1:0] size;
    logic               is_free;
  } block_t;

  logic                   clk_i;
  logic                   rst_n;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // request_size, release_address
  logic [0:0]             s_axis_tuser;   // command
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // granted_address
  logic [1:0]             m_axis_tuser;   // status
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [ARENA_W-1:0]     cfg_data;

  // predicted block table and its outstanding results
  block_t      arena_blocks [TABLE_DEPTH];
  int unsigned arena_block_count;
  int unsigned arena_now;
  outcome_t    awaited_outcomes [$];
  outcome_t    head_outcome;

  int unsigned sender_idle_pct;
  int unsigned stall_pct;
  int unsigned outlet_hold;
  int unsigned error_count;

  first_fit_block_allocator_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD_NS / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void reload_blocks(logic [ARENA_W-1:0] value);
    int unsigned span;
    span = value;
    if (span < MIN_BYTES) span = MIN_BYTES;
    if (span > ARENA_CEILING) span = ARENA_CEILING;
    foreach (arena_blocks[j]) arena_blocks[j] = '0;
    arena_blocks[0].size    = ARENA_W'(span);
    arena_blocks[0].is_free = 1'b1;
    arena_block_count       = 1;
    arena_now               = span;
  endfunction

  function automatic void drop_block(int unsigned idx);
    int unsigned k;
    for (k = idx; k + 1 < arena_block_count; k++) arena_blocks[k] = arena_blocks[k + 1];
    arena_block_count--;
    arena_blocks[arena_block_count] = '0;
  endfunction

  // a single merge: idx swallows its successor when that one is free
  function automatic void absorb_successor(int unsigned idx);
    if (idx + 1 < arena_block_count && arena_blocks[idx + 1].is_free) begin
      arena_blocks[idx].size = arena_blocks[idx].size + arena_blocks[idx + 1].size;
      drop_block(idx + 1);
    end
  endfunction

  function automatic outcome_t predict_outcome(cmd_e cmd, logic [REQ_W-1:0] req,
                                               logic [REL_ADDR_W-1:0] rel);
    outcome_t     res;
    logic [TOT_W-1:0] need;
    int unsigned  i;
    int unsigned  k;
    res.status  = STAT_OK;
    res.granted = '0;
    if (cmd == CMD_ALLOC) begin
      if (req == '0) begin
        res.status = STAT_IGNORED;
        return res;
      end
      need = TOT_W'(req) + TOT_W'(ALIGN_BYTES - 1);
      need = need & ~TOT_W'(ALIGN_BYTES - 1);
      need = need + TOT_W'(HDR_BYTES);
      if (need < MIN_BYTES) need = TOT_W'(MIN_BYTES);
      for (i = 0; i < arena_block_count; i++) begin
        if (arena_blocks[i].is_free && arena_blocks[i].size >= need) begin
          // split off the tail only if it is big enough and a slot is spare
          if (arena_blocks[i].size >= need + MIN_BYTES && arena_block_count < TABLE_DEPTH) begin
            for (k = arena_block_count; k > i + 1; k--) arena_blocks[k] = arena_blocks[k - 1];
            arena_blocks[i + 1].start   = ARENA_W'(arena_blocks[i].start + need);
            arena_blocks[i + 1].size    = ARENA_W'(arena_blocks[i].size - need);
            arena_blocks[i + 1].is_free = 1'b1;
            arena_block_count++;
            arena_blocks[i].size = ARENA_W'(need);
          end
          arena_blocks[i].is_free = 1'b0;
          res.granted = OUT_ADDR_W'(arena_blocks[i].start + HDR_BYTES);
          return res;
        end
      end
      res.status = STAT_NO_FIT;
      return res;
    end
    if (rel == '0) begin
      res.status = STAT_IGNORED;
      return res;
    end
    for (i = 0; i < arena_block_count; i++) begin
      if (arena_blocks[i].start + HDR_BYTES == rel) begin
        arena_blocks[i].is_free = 1'b1;
        if (i > 0 && arena_blocks[i - 1].is_free) absorb_successor(i - 1);
        else absorb_successor(i);
        return res;
      end
    end
    res.status = STAT_UNKNOWN;
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic issue_request(cmd_e cmd, logic [REQ_W-1:0] req, logic [REL_ADDR_W-1:0] rel);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{PAD_W{1'b0}}, rel, req};
    do @(posedge clk_i); while (!s_axis_tready);
    awaited_outcomes.push_back(predict_outcome(cmd, req, rel));
  endtask

  task automatic wait_drained();
    while (awaited_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_arena(logic [ARENA_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reload_blocks(value);
  endtask

  function automatic logic [REQ_W-1:0] pick_size();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 4)  return '0;
    if (sel < 9)  return REQ_W'($urandom);
    if (sel < 65) return REQ_W'($urandom_range(1, 200));
    if (sel < 85) return REQ_W'($urandom_range(1, 2048));
    return REQ_W'($urandom_range(1, arena_now));
  endfunction

  // mostly live payloads, some double frees, stray and null addresses
  function automatic logic [REL_ADDR_W-1:0] pick_release();
    int unsigned sel;
    int unsigned idx;
    int unsigned k;
    int unsigned j;
    sel = $urandom_range(99);
    idx = $urandom_range(0, arena_block_count - 1);
    if (sel < 70) begin
      for (k = 0; k < arena_block_count; k++) begin
        j = (idx + k) % arena_block_count;
        if (!arena_blocks[j].is_free) return REL_ADDR_W'(arena_blocks[j].start + HDR_BYTES);
      end
    end
    if (sel < 82) return REL_ADDR_W'(arena_blocks[idx].start + HDR_BYTES);
    if (sel < 92) return REL_ADDR_W'($urandom);
    if (sel < 96) return '0;
    return REL_ADDR_W'(arena_blocks[idx].start + HDR_BYTES + $urandom_range(1, 15));
  endfunction

  task automatic random_item(int unsigned alloc_pct);
    if ($urandom_range(99) < alloc_pct) issue_request(CMD_ALLOC, pick_size(), REL_ADDR_W'($urandom));
    else issue_request(CMD_FREE, REQ_W'($urandom), pick_release());
  endtask

  // ---------------------------------------------------------------- tests

  // reset arena: ignored items, no fit, splits, stray and double frees, both merges
  task automatic test_alloc_free_basics();
    sender_idle_pct = 25;
    stall_pct       = 25;
    issue_request(CMD_ALLOC, '0, 20'hFFFFF);
    issue_request(CMD_FREE, 21'h1FFFFF, '0);
    issue_request(CMD_ALLOC, 21'h1FFFFF, '0);
    issue_request(CMD_ALLOC, 21'h100000, '0);
    issue_request(CMD_ALLOC, 21'd1, '0);
    issue_request(CMD_ALLOC, 21'd16, '0);
    issue_request(CMD_ALLOC, 21'd40, '0);
    issue_request(CMD_ALLOC, 21'd100, '0);
    issue_request(CMD_FREE, '0, 20'hFFFFF);
    issue_request(CMD_FREE, '0, 20'd26);
    issue_request(CMD_FREE, '0, 20'd89);
    issue_request(CMD_FREE, '0, 20'd89);
    issue_request(CMD_FREE, '0, 20'd25);
    issue_request(CMD_FREE, '0, 20'd153);
    issue_request(CMD_ALLOC, 21'd50, '0);
  endtask

  // arena register beyond both ends of its range and just inside the lower one
  task automatic test_arena_limits();
    write_arena('0);
    issue_request(CMD_ALLOC, 21'd32, '0);
    issue_request(CMD_ALLOC, 21'd1, '0);
    issue_request(CMD_FREE, '0, 20'd25);
    issue_request(CMD_ALLOC, 21'd33, '0);
    write_arena(21'd63);
    issue_request(CMD_ALLOC, 21'd1, '0);
    write_arena(21'd65);
    issue_request(CMD_ALLOC, 21'd1, '0);
    write_arena(21'h100001);
    issue_request(CMD_ALLOC, 21'd1048544, '0);
    issue_request(CMD_ALLOC, 21'd1, '0);
    issue_request(CMD_FREE, '0, 20'd25);
    write_arena(21'h1FFFFF);
    issue_request(CMD_ALLOC, 21'd1048575, '0);
  endtask

  task automatic test_random_traffic(int unsigned count, logic [ARENA_W-1:0] arena,
                                     int unsigned send_idle, int unsigned hold_pct,
                                     int unsigned alloc_pct);
    write_arena(arena);
    sender_idle_pct = send_idle;
    stall_pct       = hold_pct;
    repeat (count) random_item(alloc_pct);
  endtask

  // result side blocked for a long stretch while requests keep coming
  task automatic test_backpressure();
    write_arena(21'd2048);
    sender_idle_pct = 0;
    stall_pct       = 0;
    outlet_hold     = 400;
    repeat (40) random_item(60);
    repeat (160) random_item(60);
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (outlet_hold > 0) begin
        outlet_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (awaited_outcomes.size() == 0) begin
        $error("unexpected result: status %0d granted_address %0h",
               m_axis_tuser, m_axis_tdata[OUT_ADDR_W-1:0]);
        error_count++;
      end else begin
        head_outcome = awaited_outcomes.pop_front();
        if (m_axis_tuser !== head_outcome.status) begin
          $error("status: expected %0d, got %0d", head_outcome.status, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata[OUT_ADDR_W-1:0] !== head_outcome.granted) begin
          $error("granted_address: expected %0h, got %0h",
                 head_outcome.granted, m_axis_tdata[OUT_ADDR_W-1:0]);
          error_count++;
        end
      end
    end
  end

  initial begin
    #(WATCHDOG_CYCLES * CLK_PERIOD_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n           <= 1'b0;
    s_axis_tvalid   <= 1'b0;
    s_axis_tdata    <= '0;
    s_axis_tuser    <= CMD_ALLOC;
    cfg_valid       <= 1'b0;
    cfg_data        <= '0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    outlet_hold     = 0;
    error_count     = 0;
    reload_blocks(ARENA_RESET);
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    test_alloc_free_basics();
    test_arena_limits();
    test_random_traffic(450, 21'h100000, 0, 0, 70);
    test_random_traffic(350, 21'd4096, 51, 0, 60);
    test_random_traffic(450, ARENA_W'($urandom_range(MIN_BYTES, ARENA_CEILING)), 0, 51, 60);
    test_random_traffic(400, 21'h1FFFFF, 25, 25, 65);
    test_backpressure();

    s_axis_tvalid <= 1'b0;
    wait_drained();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
